### design/e2q_pkg.sv
package e2q_pkg;

  // Field widths and fixed-point formats.
  localparam int AngleW        = 16;
  localparam int OutW          = 16;
  localparam int AngleFracBits = 13;
  localparam int OutFracBits   = 14;
  localparam int CordicStages  = 16;

  // Stage count, limited to the size of the arctangent table.
  localparam int AtanDepth = 32;
  localparam int AtanIdxW  = 5;
  localparam int NStages   = (CordicStages > AtanDepth) ? AtanDepth : CordicStages;
  localparam int StageIdxW = (NStages > 1) ? $clog2(NStages) : 1;

  // Internal Q30 datapath.
  localparam int Q30Bits   = 30;
  localparam int DataW     = 34;
  localparam int TrigW     = 32;
  localparam int ProdW     = 2 * TrigW;
  localparam int SumW      = ProdW + 1;
  localparam int HalfShift = Q30Bits - 1 - AngleFracBits;
  localparam int OutShift  = 2 * Q30Bits - OutFracBits;

  localparam int NumAxes   = 3;
  localparam int AxisRoll  = 0;
  localparam int AxisPitch = 1;
  localparam int AxisYaw   = 2;

  localparam logic signed [DataW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [DataW-1:0] TwoPiQ30  = 34'sd6746518852;
  localparam logic signed [DataW-1:0] HalfPiQ30 = 34'sd1686629713;

  // CORDIC start value: the asymptotic inverse gain plus a stage-count correction.
  localparam longint GainInfQ30  = 652032874;
  localparam longint GainCorrQ30 = 434688583;
  localparam longint GainFull    = (2 * NStages < 63) ?
                                   GainInfQ30 + (GainCorrQ30 >>> (2 * NStages)) :
                                   GainInfQ30;
  localparam logic signed [DataW-1:0] GainQ30 = DataW'(GainFull);

  // atan(2^-i) in Q30.
  localparam logic [30:0] AtanTable [AtanDepth] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158,
    31'd67021686,  31'd33543515,  31'd16775850,  31'd8388437,
    31'd4194282,   31'd2097149,   31'd1048575,   31'd524287,
    31'd262143,    31'd131071,    31'd65535,     31'd32767,
    31'd16383,     31'd8191,      31'd4095,      31'd2047,
    31'd1023,      31'd511,       31'd255,       31'd127,
    31'd63,        31'd31,        31'd15,        31'd8,
    31'd4,         31'd2,         31'd1,         31'd0
  };

  // Rotation state of one angle as it moves down the CORDIC chain.
  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [DataW-1:0] z;
    logic                    flip;
  } axis_t;

  typedef axis_t [NumAxes-1:0] axes_t;

  function automatic logic signed [DataW-1:0] atan_q30(input logic [StageIdxW-1:0] idx);
    logic [AtanIdxW-1:0] full_idx;
    full_idx = AtanIdxW'(idx);
    return $signed({{(DataW-31){1'b0}}, AtanTable[full_idx]});
  endfunction

  // Halve the angle into Q30 and fold it into plus or minus pi/2.
  function automatic axis_t reduce_angle(input logic signed [AngleW-1:0] angle);
    logic signed [DataW-1:0] z;
    axis_t                   r;
    z = DataW'(angle) <<< HalfShift;
    if (z >= PiQ30) begin
      z = z - TwoPiQ30;
    end else if (z < -PiQ30) begin
      z = z + TwoPiQ30;
    end
    r.flip = 1'b0;
    if (z > HalfPiQ30) begin
      z      = z - PiQ30;
      r.flip = 1'b1;
    end else if (z < -HalfPiQ30) begin
      z      = z + PiQ30;
      r.flip = 1'b1;
    end
    r.x = GainQ30;
    r.y = '0;
    r.z = z;
    return r;
  endfunction

endpackage

### design/e2q_if.sv
// Input channel: one orientation per item.
interface e2q_angle_if;
  import e2q_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [AngleW-1:0] roll_angle;
  logic signed [AngleW-1:0] pitch_angle;
  logic signed [AngleW-1:0] yaw_angle;

  modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
                  input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle, input yaw_angle,
                  output ready);
endinterface

// Output channel: one quaternion per item.
interface e2q_quat_if;
  import e2q_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] quat_w;
  logic signed [OutW-1:0] quat_x;
  logic signed [OutW-1:0] quat_y;
  logic signed [OutW-1:0] quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                  input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
                  output ready);
endinterface

### design/e2q_cordic_cell.sv
module e2q_cordic_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [e2q_pkg::StageIdxW-1:0]  stage_i,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  e2q_pkg::axes_t                 data_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output e2q_pkg::axes_t                 data_o
);
  import e2q_pkg::*;

  logic                    valid_q;
  axes_t                   data_q;
  axes_t                   data_d;
  logic signed [DataW-1:0] atan_val;
  logic signed [DataW-1:0] x_sh [NumAxes];
  logic signed [DataW-1:0] y_sh [NumAxes];

  // The stage holds a new item when it is empty or its item moves on.
  assign ready_o = ~valid_q | ready_i;

  // One micro-rotation for each of the three angles.
  always_comb begin
    atan_val = atan_q30(stage_i);
    data_d   = data_i;
    for (int a = 0; a < NumAxes; a++) begin
      x_sh[a] = data_i[a].x >>> stage_i;
      y_sh[a] = data_i[a].y >>> stage_i;
      if (!data_i[a].z[DataW-1]) begin
        data_d[a].x = data_i[a].x - y_sh[a];
        data_d[a].y = data_i[a].y + x_sh[a];
        data_d[a].z = data_i[a].z - atan_val;
      end else begin
        data_d[a].x = data_i[a].x + y_sh[a];
        data_d[a].y = data_i[a].y - x_sh[a];
        data_d[a].z = data_i[a].z + atan_val;
      end
    end
  end

  // Occupancy of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Rotation state.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/e2q_combine.sv
module e2q_combine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  e2q_pkg::axes_t  data_i,
  e2q_quat_if.source      quat_o
);
  import e2q_pkg::*;

  localparam logic signed [ProdW-1:0] PairHalf = ProdW'(1) <<< (Q30Bits - 1);
  localparam logic signed [SumW-1:0]  OutHalf  = SumW'(1) <<< (OutShift - 1);
  localparam logic signed [SumW-1:0]  OneOut   = SumW'(1) <<< OutFracBits;
  localparam int NumTerms = 8;

  // Round a Q60 sum to the output format and clamp to plus or minus one.
  function automatic logic signed [OutW-1:0] finish(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] t;
    t = (s + OutHalf) >>> OutShift;
    if (t > OneOut) begin
      t = OneOut;
    end else if (t < -OneOut) begin
      t = -OneOut;
    end
    return OutW'(t);
  endfunction

  function automatic logic signed [TrigW-1:0] pair_round(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] t;
    t = (p + PairHalf) >>> Q30Bits;
    return TrigW'(t);
  endfunction

  logic va_q, vb_q, vc_q, vd_q;
  logic ra, rb, rc, rd;

  logic signed [TrigW-1:0] cos_q [NumAxes];
  logic signed [TrigW-1:0] sin_q [NumAxes];

  logic signed [ProdW-1:0] crcp_p, srsp_p, srcp_p, crsp_p;
  logic signed [TrigW-1:0] crcp_q, srsp_q, srcp_q, crsp_q, cy_q, sy_q;

  logic signed [ProdW-1:0] term_d [NumTerms];
  logic signed [ProdW-1:0] term_q [NumTerms];

  logic signed [OutW-1:0]  w_q, x_q, y_q, z_q;

  // Ready chain from the output register back to the chain of cells.
  assign rd      = ~vd_q | quat_o.ready;
  assign rc      = ~vc_q | rd;
  assign rb      = ~vb_q | rc;
  assign ra      = ~va_q | rb;
  assign ready_o = ra;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (ra) va_q <= valid_i;
      if (rb) vb_q <= va_q;
      if (rc) vc_q <= vb_q;
      if (rd) vd_q <= vc_q;
    end
  end

  // Undo the half-turn fold by negating sine and cosine.
  always_ff @(posedge clk_i) begin
    if (valid_i && ra) begin
      for (int a = 0; a < NumAxes; a++) begin
        cos_q[a] <= TrigW'(data_i[a].flip ? -data_i[a].x : data_i[a].x);
        sin_q[a] <= TrigW'(data_i[a].flip ? -data_i[a].y : data_i[a].y);
      end
    end
  end

  // Roll and pitch pair products, rounded back to Q30.
  always_comb begin
    crcp_p = ProdW'(cos_q[AxisRoll]) * ProdW'(cos_q[AxisPitch]);
    srsp_p = ProdW'(sin_q[AxisRoll]) * ProdW'(sin_q[AxisPitch]);
    srcp_p = ProdW'(sin_q[AxisRoll]) * ProdW'(cos_q[AxisPitch]);
    crsp_p = ProdW'(cos_q[AxisRoll]) * ProdW'(sin_q[AxisPitch]);
  end

  always_ff @(posedge clk_i) begin
    if (va_q && rb) begin
      crcp_q <= pair_round(crcp_p);
      srsp_q <= pair_round(srsp_p);
      srcp_q <= pair_round(srcp_p);
      crsp_q <= pair_round(crsp_p);
      cy_q   <= cos_q[AxisYaw];
      sy_q   <= sin_q[AxisYaw];
    end
  end

  // Products with the yaw terms, kept in Q60.
  always_comb begin
    term_d[0] = ProdW'(crcp_q) * ProdW'(cy_q);
    term_d[1] = ProdW'(srsp_q) * ProdW'(sy_q);
    term_d[2] = ProdW'(srcp_q) * ProdW'(cy_q);
    term_d[3] = ProdW'(crsp_q) * ProdW'(sy_q);
    term_d[4] = ProdW'(crsp_q) * ProdW'(cy_q);
    term_d[5] = ProdW'(srcp_q) * ProdW'(sy_q);
    term_d[6] = ProdW'(crcp_q) * ProdW'(sy_q);
    term_d[7] = ProdW'(srsp_q) * ProdW'(cy_q);
  end

  always_ff @(posedge clk_i) begin
    if (vb_q && rc) begin
      term_q <= term_d;
    end
  end

  // Sum, round and saturate each component into the output register.
  always_ff @(posedge clk_i) begin
    if (vc_q && rd) begin
      w_q <= finish(SumW'(term_q[0]) + SumW'(term_q[1]));
      x_q <= finish(SumW'(term_q[2]) - SumW'(term_q[3]));
      y_q <= finish(SumW'(term_q[4]) + SumW'(term_q[5]));
      z_q <= finish(SumW'(term_q[6]) - SumW'(term_q[7]));
    end
  end

  assign quat_o.valid  = vd_q;
  assign quat_o.quat_w = w_q;
  assign quat_o.quat_x = x_q;
  assign quat_o.quat_y = y_q;
  assign quat_o.quat_z = z_q;

endmodule

### design/euler_to_quaternion_top.sv
// Stages from input accept to result valid: angle fold, one cell per CORDIC stage,
// sign fix, pair products, triple products, round and saturate.
// Throughput: one item per cycle while the output is not stalled; every cell
// and product stage is a pipeline register.
// Reset clears only the valid bits of the pipeline; no item state survives reset.
module euler_to_quaternion_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  e2q_angle_if.sink   angles_i,
  e2q_quat_if.source  quat_o
);
  import e2q_pkg::*;

  logic  fold_valid_q;
  logic  fold_ready;
  axes_t fold_q;
  axes_t fold_d;

  logic  chain_valid [NStages+1];
  logic  chain_ready [NStages+1];
  axes_t chain_data  [NStages+1];

  // Halve and fold each angle into the CORDIC convergence range.
  always_comb begin
    fold_d[AxisRoll]  = reduce_angle(angles_i.roll_angle);
    fold_d[AxisPitch] = reduce_angle(angles_i.pitch_angle);
    fold_d[AxisYaw]   = reduce_angle(angles_i.yaw_angle);
  end

  assign fold_ready     = ~fold_valid_q | chain_ready[0];
  assign angles_i.ready = fold_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_valid_q <= 1'b0;
    end else if (fold_ready) begin
      fold_valid_q <= angles_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (angles_i.valid && fold_ready) begin
      fold_q <= fold_d;
    end
  end

  assign chain_valid[0] = fold_valid_q;
  assign chain_data[0]  = fold_q;

  // Chain of CORDIC cells, one micro-rotation per cell.
  for (genvar k = 0; k < NStages; k++) begin : g_cell
    e2q_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (StageIdxW'(k)),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  // Sign fix, pair and triple products and output register.
  e2q_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[NStages]),
    .ready_o (chain_ready[NStages]),
    .data_i  (chain_data[NStages]),
    .quat_o  (quat_o)
  );

endmodule

### tb/e2q_quat_checker.sv
// Watches both channels of the Euler-to-quaternion block, predicts the
// quaternion for every accepted orientation and compares it with the
// quaternions that come out, in order.
module e2q_quat_checker
  import e2q_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  e2q_angle_if  angles_i,
  e2q_quat_if   quat_i,
  output int    err_count_o,
  output int    pending_o,
  output int    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     MaxReports  = 10;
  localparam int     TrigFrac    = 30;
  localparam longint HalfTurn    = 64'sd3373259426;
  localparam longint QuarterTurn = 64'sd1686629713;
  localparam longint FullTurn    = 2 * HalfTurn;
  localparam longint StartGain   = GainInfQ30 +
                                   ((2 * NStages < 63) ? (GainCorrQ30 >>> (2 * NStages)) : 0);

  // Index 0 holds w, then x, y and z.
  typedef logic [3:0][OutW-1:0] quat_t;

  typedef struct packed {
    logic signed [AngleW-1:0] roll;
    logic signed [AngleW-1:0] pitch;
    logic signed [AngleW-1:0] yaw;
    quat_t                    quat;
  } orientation_t;

  orientation_t expected_quats [$];
  int           n_err     = 0;
  int           n_checked = 0;
  string        comp_name [4] = '{"w", "x", "y", "z"};

  // Round half up and drop s fraction bits; arithmetic shift gives the floor.
  function automatic longint round_half_up(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Cosine and sine of half the angle, in Q30, from the folded CORDIC.
  function automatic void half_angle_trig(input logic signed [AngleW-1:0] angle,
                                          output longint cos_q30, output longint sin_q30);
    longint z;
    longint x;
    longint y;
    longint nx;
    longint step;
    bit     flip;
    int     i;
    z = longint'(angle) * (longint'(1) <<< (TrigFrac - 1 - AngleFracBits));
    z = z % FullTurn;
    if (z >= HalfTurn) z -= FullTurn;
    if (z < -HalfTurn) z += FullTurn;

    // Fold into plus or minus pi/2 and remember to negate both results.
    flip = 1'b0;
    if (z > QuarterTurn) begin
      z    -= HalfTurn;
      flip  = 1'b1;
    end else if (z < -QuarterTurn) begin
      z    += HalfTurn;
      flip  = 1'b1;
    end

    x = StartGain;
    y = 0;
    for (i = 0; i < NStages; i++) begin
      step = longint'(AtanTable[i]);
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= step;
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += step;
      end
      x = nx;
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endfunction

  // Q60 sum to the output format, clamped to plus or minus one.
  function automatic logic [OutW-1:0] to_output(input longint q60);
    longint v;
    longint one;
    v   = round_half_up(q60, 2 * TrigFrac - OutFracBits);
    one = longint'(1) <<< OutFracBits;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return OutW'(v);
  endfunction

  // ZYX triple products of the six half-angle values.
  function automatic quat_t predict_quat(input logic signed [AngleW-1:0] roll,
                                         input logic signed [AngleW-1:0] pitch,
                                         input logic signed [AngleW-1:0] yaw);
    longint cr, sr, cp, sp, cy, sy;
    longint crcp, srsp, srcp, crsp;
    quat_t  q;
    half_angle_trig(roll, cr, sr);
    half_angle_trig(pitch, cp, sp);
    half_angle_trig(yaw, cy, sy);
    crcp = round_half_up(cr * cp, TrigFrac);
    srsp = round_half_up(sr * sp, TrigFrac);
    srcp = round_half_up(sr * cp, TrigFrac);
    crsp = round_half_up(cr * sp, TrigFrac);
    q[0] = to_output(crcp * cy + srsp * sy);
    q[1] = to_output(srcp * cy - crsp * sy);
    q[2] = to_output(crsp * cy + srcp * sy);
    q[3] = to_output(crcp * sy - srsp * cy);
    return q;
  endfunction

  // Check each delivered quaternion first, then queue the prediction for a new item.
  always @(posedge clk_i) begin : watch
    quat_t        got;
    orientation_t want;
    orientation_t item;
    int           k;
    if (rst_ni) begin
      if (quat_i.valid && quat_i.ready) begin
        got = {quat_i.quat_z, quat_i.quat_y, quat_i.quat_x, quat_i.quat_w};
        if (expected_quats.size() == 0) begin
          n_err++;
          if (n_err <= MaxReports) begin
            $display("[%0t] Quaternion with no orientation pending: w %0d x %0d y %0d z %0d",
                     $realtime, $signed(got[0]), $signed(got[1]), $signed(got[2]),
                     $signed(got[3]));
          end
        end else begin
          want = expected_quats.pop_front();
          n_checked++;
          for (k = 0; k < 4; k++) begin
            if (got[k] !== want.quat[k]) begin
              n_err++;
              if (n_err <= MaxReports) begin
                $display("[%0t] quat_%s for roll %0d pitch %0d yaw %0d: expected %0d, got %0d",
                         $realtime, comp_name[k], want.roll, want.pitch, want.yaw,
                         $signed(want.quat[k]), $signed(got[k]));
              end
            end
          end
        end
      end

      if (angles_i.valid && angles_i.ready) begin
        item.roll  = angles_i.roll_angle;
        item.pitch = angles_i.pitch_angle;
        item.yaw   = angles_i.yaw_angle;
        item.quat  = predict_quat(item.roll, item.pitch, item.yaw);
        expected_quats.push_back(item);
      end
    end
    err_count_o <= n_err;
    pending_o   <= expected_quats.size();
    checked_o   <= n_checked;
  end

endmodule

### tb/tb_top.sv
// Drives orientations into the Euler-to-quaternion block with random source
// gaps and sink stalls, and gives the verdict from the checker's error count.
module tb_top
  import e2q_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PipeLatency   = NStages + 5;
  localparam int AngleLimit    = 25736;
  localparam int DirectedCount = 18;
  localparam int RandomItems   = 932;
  localparam int CycleLimit    = 1000000;

  localparam int SpecialAngles [9] = '{0, 25736, -25736, 12868, -12868, 25735, -25735, 1, -1};

  // Corners: zero, plus or minus pi on each axis, full 16-bit extremes beyond pi,
  // the fold points at plus or minus pi/2 of the half angle, and tiny angles.
  localparam int DirectedSet [DirectedCount][3] = '{
    '{0, 0, 0},
    '{25736, 0, 0},
    '{-25736, 0, 0},
    '{0, 25736, 0},
    '{0, -25736, 0},
    '{0, 0, 25736},
    '{0, 0, -25736},
    '{25736, 25736, 25736},
    '{-25736, -25736, -25736},
    '{32767, -32768, 32767},
    '{-32768, 32767, -32768},
    '{25737, -25737, 25735},
    '{12868, 12868, 12868},
    '{-12868, -12868, -12868},
    '{12868, -12868, 0},
    '{1, -1, 1},
    '{-1, -1, -1},
    '{6434, 19302, -6434}
  };

  logic clk_i;
  logic rst_ni;
  int   err_count;
  int   n_pending;
  int   n_checked;
  int   cycle_count = 0;

  e2q_angle_if angles ();
  e2q_quat_if  quat ();

  euler_to_quaternion_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .angles_i (angles),
    .quat_o   (quat)
  );

  e2q_quat_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .angles_i    (angles),
    .quat_i      (quat),
    .err_count_o (err_count),
    .pending_o   (n_pending),
    .checked_o   (n_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int idle_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly angles within plus or minus pi, some raw 16-bit patterns, some corners.
  function automatic logic signed [AngleW-1:0] random_angle();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return AngleW'(int'($urandom_range(0, 2 * AngleLimit)) - AngleLimit);
    if (pick < 92) return AngleW'($urandom);
    return AngleW'(SpecialAngles[$urandom_range(0, 8)]);
  endfunction

  // Present one orientation after an optional gap and hold it until accepted.
  task automatic send_orientation(input logic signed [AngleW-1:0] roll,
                                  input logic signed [AngleW-1:0] pitch,
                                  input logic signed [AngleW-1:0] yaw,
                                  input int gap);
    if (gap > 0) begin
      angles.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    angles.valid       <= 1'b1;
    angles.roll_angle  <= roll;
    angles.pitch_angle <= pitch;
    angles.yaw_angle   <= yaw;
    do @(posedge clk_i); while (!angles.ready);
  endtask

  // Sink pacing: runs of ready broken by stalls, with long stall-free stretches.
  initial begin : sink_pacing
    int run;
    quat.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 16);
      repeat (run) begin
        @(posedge clk_i);
        quat.ready <= 1'b1;
      end
      run = idle_cycles();
      repeat (run) begin
        @(posedge clk_i);
        quat.ready <= 1'b0;
      end
    end
  end

  // Safety net against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d quaternions outstanding.",
               cycle_count, n_pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int n_sent;
    int idle_on;
    int i;
    n_sent             = 0;
    idle_on            = 0;
    rst_ni             <= 1'b0;
    angles.valid       <= 1'b0;
    angles.roll_angle  <= '0;
    angles.pitch_angle <= '0;
    angles.yaw_angle   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners, back to back.
    for (i = 0; i < DirectedCount; i++) begin
      send_orientation(AngleW'(DirectedSet[i][0]), AngleW'(DirectedSet[i][1]),
                       AngleW'(DirectedSet[i][2]), 0);
      n_sent++;
    end

    // Random orientations; source gaps are switched on and off in stretches.
    for (i = 0; i < RandomItems; i++) begin
      if (i % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_orientation(random_angle(), random_angle(), random_angle(),
                       idle_on ? idle_cycles() : 0);
      n_sent++;
    end
    angles.valid <= 1'b0;

    // Drain the pipeline, then keep watching for stray results.
    do @(posedge clk_i); while (n_pending != 0);
    repeat (PipeLatency + 10) @(posedge clk_i);

    $display("Sent %0d orientations: %0d directed corners, then random angles within",
             n_sent, DirectedCount);
    $display("and beyond plus or minus pi under random gaps and stalls; %0d quaternions checked.",
             n_checked);
    if (err_count == 0 && n_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
